### hw/rtl/nsfc_pkg.sv
`timescale 1ns / 1ps

package nsfc_pkg;

  // character codes
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] NoData   = 8'hFF;

  // counter limits
  localparam logic [6:0] CountCap    = 7'd127;
  localparam logic [6:0] MinCheckLen = 7'd5;
  localparam logic [6:0] MinKindLen  = 7'd7;
  localparam logic [6:0] ResetMaxLen = 7'd90;

  // configuration register indexes
  localparam logic [1:0] RegCheckEnable = 2'd0;
  localparam logic [1:0] RegMaxLength   = 2'd1;

  // sentence kinds
  localparam logic [2:0] KindGga   = 3'd0;
  localparam logic [2:0] KindRmc   = 3'd1;
  localparam logic [2:0] KindGsv   = 3'd2;
  localparam logic [2:0] KindGll   = 3'd3;
  localparam logic [2:0] KindGsa   = 3'd4;
  localparam logic [2:0] KindVtg   = 3'd5;
  localparam logic [2:0] KindTxt   = 3'd6;
  localparam logic [2:0] KindOther = 3'd7;

  typedef struct packed {
    logic       check_enable;
    logic [6:0] max_length;
  } cfg_t;

  // result fields, listed from the highest bit down
  typedef struct packed {
    logic [7:0] computed_xor;
    logic [6:0] sentence_length;
    logic       check_passed;
    logic [2:0] sentence_kind;
  } result_t;

  // uppercase hex character for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

  // sentence type from the three type characters
  function automatic logic [2:0] classify(input logic [23:0] chars);
    logic [2:0] kind;
    case (chars)
      {"G", "G", "A"}: kind = KindGga;
      {"R", "M", "C"}: kind = KindRmc;
      {"G", "S", "V"}: kind = KindGsv;
      {"G", "L", "L"}: kind = KindGll;
      {"G", "S", "A"}: kind = KindGsa;
      {"V", "T", "G"}: kind = KindVtg;
      {"T", "X", "T"}: kind = KindTxt;
      default:         kind = KindOther;
    endcase
    return kind;
  endfunction

endpackage

### hw/rtl/nsfc_framer.sv
`timescale 1ns / 1ps

module nsfc_framer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nsfc_pkg::cfg_t       cfg_i,
  input  logic                 step_i,
  input  logic [7:0]           char_i,
  output logic                 res_valid_o,
  output nsfc_pkg::result_t    res_o
);

  logic       in_sentence_q, in_sentence_d;
  logic [6:0] count_q, count_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] recent_q [3];
  logic [7:0] recent_d [3];
  logic [7:0] kind_q [3];
  logic [7:0] kind_d [3];

  logic [6:0] len_next;
  logic [7:0] trail_xor;
  logic       trail_ok;

  // closing values; the result counts only when a line feed ends the sentence
  assign len_next  = count_q + 7'd1;
  assign trail_xor = xor_q ^ recent_q[0] ^ recent_q[1] ^ recent_q[2];
  assign trail_ok  = (recent_q[0] == nsfc_pkg::ChStar) &&
                     (recent_q[1] == nsfc_pkg::hex_char(trail_xor[7:4])) &&
                     (recent_q[2] == nsfc_pkg::hex_char(trail_xor[3:0]));

  always_comb begin
    in_sentence_d = in_sentence_q;
    count_d       = count_q;
    xor_d         = xor_q;
    recent_d      = recent_q;
    kind_d        = kind_q;
    res_valid_o   = 1'b0;

    res_o.sentence_length = len_next;
    if (len_next < nsfc_pkg::MinKindLen) begin
      res_o.sentence_kind = nsfc_pkg::KindOther;
    end else begin
      res_o.sentence_kind = nsfc_pkg::classify({kind_q[0], kind_q[1], kind_q[2]});
    end
    if (len_next < nsfc_pkg::MinCheckLen) begin
      res_o.computed_xor = 8'd0;
      res_o.check_passed = !cfg_i.check_enable;
    end else begin
      res_o.computed_xor = trail_xor;
      res_o.check_passed = trail_ok || !cfg_i.check_enable;
    end

    if (step_i && char_i != nsfc_pkg::NoData) begin
      if (char_i == nsfc_pkg::ChDollar) begin
        // start (or restart) a sentence
        in_sentence_d = 1'b1;
        count_d       = 7'd1;
        xor_d         = 8'd0;
        recent_d      = '{default: 8'd0};
        kind_d        = '{default: 8'd0};
      end else if (count_q > cfg_i.max_length || count_q == nsfc_pkg::CountCap) begin
        // too long: abort without a result
        in_sentence_d = 1'b0;
        count_d       = 7'd0;
        xor_d         = 8'd0;
        recent_d      = '{default: 8'd0};
        kind_d        = '{default: 8'd0};
      end else if (in_sentence_q && char_i != nsfc_pkg::ChCr) begin
        // hold the type characters at positions 3 to 5
        case (count_q)
          7'd3:    kind_d[0] = char_i;
          7'd4:    kind_d[1] = char_i;
          7'd5:    kind_d[2] = char_i;
          default: ;
        endcase
        count_d = len_next;
        if (char_i != nsfc_pkg::ChLf) begin
          xor_d       = xor_q ^ char_i;
          recent_d[0] = recent_q[1];
          recent_d[1] = recent_q[2];
          recent_d[2] = char_i;
        end else begin
          // line feed closes the sentence
          res_valid_o   = 1'b1;
          in_sentence_d = 1'b0;
          count_d       = 7'd0;
          xor_d         = 8'd0;
          recent_d      = '{default: 8'd0};
          kind_d        = '{default: 8'd0};
        end
      end
    end
  end

  // sentence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sentence_q <= 1'b0;
      count_q       <= 7'd0;
      xor_q         <= 8'd0;
      recent_q      <= '{default: 8'd0};
      kind_q        <= '{default: 8'd0};
    end else begin
      in_sentence_q <= in_sentence_d;
      count_q       <= count_d;
      xor_q         <= xor_d;
      recent_q      <= recent_d;
      kind_q        <= kind_d;
    end
  end

endmodule

### hw/rtl/nmea_sentence_framer_checker.sv
`timescale 1ns / 1ps

// NMEA sentence framer and checksum checker.
// Input stream: one received byte per item on s_axis_tdata; 0xFF is an idle
// byte and changes nothing. A '$' opens a sentence, a line feed closes it.
// Output stream: one item per closed sentence with its type, check result,
// length and XOR of the characters between '$' and '*'.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 check enable, 1 maximum length); other indexes are ignored.
// A byte accepted into the input register is processed as it leaves that
// register, which also loads the result of a closing line feed into the output
// register that drives m_axis_tvalid.
// Throughput: one byte per cycle while no held result stalls the input; the
// sentence state update lies between the input and output registers.
// Reset clears the sentence state, sets the check off and the maximum length
// to 90, and empties both registers.
// A stalled receiver holds the result in the output register; the input
// register still takes one more byte, after which s_axis_tready drops until
// the result is taken.
module nmea_sentence_framer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] sentence_kind, [3] check_passed,
                                      // [10:4] sentence_length,
                                      // [18:11] computed_xor, [23:19] zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i
);

  nsfc_pkg::cfg_t    cfg_q;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  nsfc_pkg::result_t out_q;
  logic              advance;
  logic              step;
  logic              res_valid;
  nsfc_pkg::result_t res;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_enable <= 1'b0;
      cfg_q.max_length   <= nsfc_pkg::ResetMaxLen;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nsfc_pkg::RegCheckEnable: cfg_q.check_enable <= cfg_data_i[0];
        nsfc_pkg::RegMaxLength:   cfg_q.max_length   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  nsfc_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (step),
    .char_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q};

endmodule
